@@ hw/rtl/btnpc_pkg.sv @@
// Shared types and constants for the button press classifier.
`default_nettype none

package btnpc_pkg;

  // Configuration data width (the widest register).
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TIMEOUT = 3'd6;

  // Input operation codes.
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_SHORT  = 2'd1,
    ST_LONG   = 2'd2,
    ST_REPEAT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    EV_SHORT  = 2'd0,
    EV_LONG   = 2'd1,
    EV_REPEAT = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic                  idle_level;
    logic [CFG_DATA_W-1:0] debounce_ms;
    logic [CFG_DATA_W-1:0] short_min_ms;
    logic [CFG_DATA_W-1:0] short_limit_ms;
    logic [CFG_DATA_W-1:0] long_min_ms;
    logic [CFG_DATA_W-1:0] repeat_period_ms;
    logic [CFG_DATA_W-1:0] repeat_timeout_ms;
  } cfg_t;

  // Press tracking state apart from the event timestamp.
  typedef struct packed {
    status_t status;
    logic    wait_release;
  } ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/btnpc_step.sv @@
// Combinational press classification for one registered word.
`default_nettype none

module btnpc_step #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 operation,
  input  wire logic [31:0]          now_ms,
  input  wire logic                 pin_level,
  input  wire btnpc_pkg::cfg_t      cfg,
  input  wire btnpc_pkg::ctrl_t     ctrl,
  input  wire logic [TIME_BITS-1:0] last_event_ms,
  output btnpc_pkg::ctrl_t          ctrl_next,
  output logic [TIME_BITS-1:0]      last_event_ms_next,
  output logic                      event_valid,
  output btnpc_pkg::event_kind_t    event_kind
);
  import btnpc_pkg::*;

  localparam int unsigned NOW_W = (TIME_BITS < 32) ? TIME_BITS : 32;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] debounce_t;
  logic [TIME_BITS-1:0] short_min_t;
  logic [TIME_BITS-1:0] short_limit_t;
  logic [TIME_BITS-1:0] long_min_t;
  logic [TIME_BITS-1:0] period_t;
  logic [TIME_BITS-1:0] timeout_t;

  assign now_t         = TIME_BITS'(now_ms[NOW_W-1:0]);
  assign elapsed       = now_t - last_event_ms;
  assign debounce_t    = TIME_BITS'(cfg.debounce_ms);
  assign short_min_t   = TIME_BITS'(cfg.short_min_ms);
  assign short_limit_t = TIME_BITS'(cfg.short_limit_ms);
  assign long_min_t    = TIME_BITS'(cfg.long_min_ms);
  assign period_t      = TIME_BITS'(cfg.repeat_period_ms);
  assign timeout_t     = TIME_BITS'(cfg.repeat_timeout_ms);

  always_comb begin
    ctrl_next          = ctrl;
    last_event_ms_next = last_event_ms;
    event_valid        = 1'b0;
    event_kind         = EV_SHORT;
    if (operation == OP_EDGE) begin
      if (ctrl.wait_release) begin
        ctrl_next.wait_release = 1'b0;
        last_event_ms_next     = now_t;
        if (elapsed >= short_min_t && elapsed < short_limit_t &&
            ctrl.status == ST_NONE) begin
          ctrl_next.status = ST_SHORT;
          event_valid      = 1'b1;
          event_kind       = EV_SHORT;
        end else begin
          ctrl_next.status = ST_NONE;
        end
      end else if (elapsed >= debounce_t) begin
        ctrl_next.wait_release = 1'b1;
        ctrl_next.status       = ST_NONE;
        last_event_ms_next     = now_t;
      end
    end else if (pin_level == cfg.idle_level) begin
      ctrl_next.wait_release = 1'b0;
    end else if (ctrl.wait_release) begin
      if (elapsed >= long_min_t && elapsed < timeout_t) begin
        ctrl_next.status       = ST_LONG;
        ctrl_next.wait_release = 1'b0;
        last_event_ms_next     = now_t;
        event_valid            = 1'b1;
        event_kind             = EV_LONG;
      end
    end else if (ctrl.status == ST_LONG || ctrl.status == ST_REPEAT) begin
      if (elapsed >= timeout_t) begin
        ctrl_next.status = ST_NONE;
      end else if (elapsed >= period_t) begin
        ctrl_next.status   = ST_REPEAT;
        last_event_ms_next = now_t;
        event_valid        = 1'b1;
        event_kind         = EV_REPEAT;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/button_press_classifier_core.sv @@
// Top level of the button press classifier: input stage, state and result stage.
// A word accepted into the input stage moves to the result register when that stage
// can take it. Throughput: one word per cycle while the receiver does not stall; the
// press state commits with the result register.
// Reset (rst, synchronous, active high) empties both stages, clears the press
// state and timestamp, and loads the configuration registers' default values.
`default_nettype none

module button_press_classifier_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Configuration write port.
  input  wire logic                               cfg_write,
  input  wire logic [btnpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [btnpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // Input channel.
  input  wire logic                               item_valid,
  output logic                                    item_stall,
  input  wire logic                               operation,
  input  wire logic [31:0]                        now_ms,
  input  wire logic                               pin_level,
  // Result channel.
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic                                    event_valid,
  output logic [1:0]                              event_kind,
  output logic                                    armed_release,
  output logic [1:0]                              press_status
);
  import btnpc_pkg::*;

  // Configuration registers. The user must write them only while no word is in flight; the block does not enforce this.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_level        <= 1'b1;
      cfg.debounce_ms       <= CFG_DATA_W'(10);
      cfg.short_min_ms      <= CFG_DATA_W'(50);
      cfg.short_limit_ms    <= CFG_DATA_W'(300);
      cfg.long_min_ms       <= CFG_DATA_W'(500);
      cfg.repeat_period_ms  <= CFG_DATA_W'(100);
      cfg.repeat_timeout_ms <= CFG_DATA_W'(1000);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IDLE_LEVEL:     cfg.idle_level        <= cfg_data[0];
        REG_DEBOUNCE:       cfg.debounce_ms       <= cfg_data;
        REG_SHORT_MIN:      cfg.short_min_ms      <= cfg_data;
        REG_SHORT_LIMIT:    cfg.short_limit_ms    <= cfg_data;
        REG_LONG_MIN:       cfg.long_min_ms       <= cfg_data;
        REG_REPEAT_PERIOD:  cfg.repeat_period_ms  <= cfg_data;
        REG_REPEAT_TIMEOUT: cfg.repeat_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage. It holds one word until the result stage can take it.
  logic        in_full;
  logic        in_operation;
  logic [31:0] in_now_ms;
  logic        in_pin_level;

  // The result stage loads from a full input stage whenever it is empty or its word leaves this cycle.
  logic advance;
  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_operation <= operation;
      in_now_ms    <= now_ms;
      in_pin_level <= pin_level;
    end
  end

  // Press state: status, armed edge and time of the last event.
  ctrl_t                ctrl;
  ctrl_t                ctrl_next;
  logic [TIME_BITS-1:0] last_event_ms;
  logic [TIME_BITS-1:0] last_event_ms_next;
  logic                 ev_valid_next;
  event_kind_t          ev_kind_next;

  btnpc_step #(
    .TIME_BITS(TIME_BITS)
  ) u_step (
    .operation          (in_operation),
    .now_ms             (in_now_ms),
    .pin_level          (in_pin_level),
    .cfg                (cfg),
    .ctrl               (ctrl),
    .last_event_ms      (last_event_ms),
    .ctrl_next          (ctrl_next),
    .last_event_ms_next (last_event_ms_next),
    .event_valid        (ev_valid_next),
    .event_kind         (ev_kind_next)
  );

  // The state commits in the same edge that the result word is loaded, so
  // each word is classified exactly once.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.status       <= ST_NONE;
      ctrl.wait_release <= 1'b0;
      last_event_ms     <= '0;
    end else if (advance) begin
      ctrl          <= ctrl_next;
      last_event_ms <= last_event_ms_next;
    end
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_valid   <= ev_valid_next;
      event_kind    <= ev_kind_next;
      armed_release <= ctrl_next.wait_release;
      press_status  <= ctrl_next.status;
    end
  end

endmodule

`default_nettype wire
